// File: hw/rtl/mrvd_pkg.sv
package mrvd_pkg;

    // Fold limits
    localparam int MAX_WORDS_DEF = 4;
    localparam int CNT_W         = 3;
    localparam int ACC_W         = 64;

    // Queue between front and back
    localparam int QDEPTH        = 2;

    // Configuration port
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_ORDER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_FORMAT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAC_BITS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_VALUE = 3'd5;

    localparam logic signed [31:0] SCALE_RESET = 32'sd65536;

    typedef struct packed {
        logic [15:0] word;
        logic        last_word;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] int_value;
        logic signed [63:0] scaled_value;
        logic               saturated;
        logic               status;
    } t_out_word;

    typedef struct packed {
        logic               byte_order;
        logic               signed_mode;
        logic               value_format;
        logic [4:0]         frac_bits;
        logic signed [31:0] scale_factor;
        logic signed [47:0] offset_value;
    } t_cfg;

    // One finished run handed from front to back
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [CNT_W-1:0] count;
        logic             too_long;
    } t_job;

endpackage

// File: hw/rtl/mrvd_front.sv
module mrvd_front
    import mrvd_pkg::*;
#(
    parameter int MAX_WORDS = MAX_WORDS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_data,
    output logic     o_push,
    output t_job     o_job,
    input  logic     i_full
);

    logic [ACC_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_long, n_long;
    logic [15:0]      swapped;
    logic             take;

    assign o_ready = !i_full;
    assign take    = i_valid && !i_full;
    assign swapped = {i_data.word[7:0], i_data.word[15:8]};

    // Fold the incoming word into the accumulator
    always_comb begin
        n_acc   = r_acc;
        n_count = r_count;
        n_long  = r_long;
        if (r_count < CNT_W'(MAX_WORDS)) begin
            if (!i_cfg.value_format && i_cfg.byte_order) begin
                n_acc = r_acc | ({48'b0, swapped} << {r_count[1:0], 4'b0000});
            end else begin
                n_acc = {r_acc[ACC_W-17:0], i_data.word};
            end
            n_count = r_count + CNT_W'(1);
        end else begin
            n_long = 1'b1;
        end
    end

    // Hand the run over on the marked word
    assign o_push = take && i_data.last_word;
    assign o_job  = '{acc: n_acc, count: n_count, too_long: n_long};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_count <= '0;
            r_long  <= 1'b0;
        end else if (take) begin
            if (i_data.last_word) begin
                r_acc   <= '0;
                r_count <= '0;
                r_long  <= 1'b0;
            end else begin
                r_acc   <= n_acc;
                r_count <= n_count;
                r_long  <= n_long;
            end
        end
    end

endmodule

// File: hw/rtl/mrvd_queue.sv
module mrvd_queue
    import mrvd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW = $clog2(QDEPTH + 1);

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store the job at the write pointer
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + QAW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + QAW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end

endmodule

// File: hw/rtl/mrvd_back.sv
module mrvd_back
    import mrvd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_job      i_job,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    typedef struct packed {
        logic [63:0] v;
        logic        scl;
        logic        status;
    } t_tag;

    logic en;

    logic        r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r_out_valid;
    t_tag        r1_tag, r2_tag, r3_tag, r4_tag, r5_tag;
    logic [63:0] r1_xmag;
    logic [31:0] r1_smag;
    logic        r1_neg, r2_neg, r3_neg;
    logic [63:0] r2_p0, r2_p1;
    logic [95:0] r3_prod;
    logic signed [95:0] r4_sp;
    logic signed [96:0] r5_sum;
    t_out_word   r_out;

    logic [63:0]        n_v;
    t_tag               n1_tag;
    logic signed [95:0] shifted;
    logic signed [96:0] n_sum;
    logic               fits;
    logic [63:0]        clipped;

    // Whole pipe moves unless the output word is stalled
    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Stage 1: width handling and magnitudes
    always_comb begin
        priority if (i_job.too_long) begin
            n_v = '0;
        end else if (i_job.count == CNT_W'(1)) begin
            n_v = i_cfg.signed_mode ? {{48{i_job.acc[15]}}, i_job.acc[15:0]}
                                    : {48'b0, i_job.acc[15:0]};
        end else if (i_job.count == CNT_W'(2)) begin
            n_v = i_cfg.signed_mode ? {{32{i_job.acc[31]}}, i_job.acc[31:0]}
                                    : {32'b0, i_job.acc[31:0]};
        end else begin
            n_v = i_job.acc;
        end
        n1_tag = '{v: n_v, scl: i_cfg.value_format && !i_job.too_long,
                   status: i_job.too_long};
    end

    // Stage 5: arithmetic shift and offset
    assign shifted = r4_sp >>> i_cfg.frac_bits;
    assign n_sum   = {shifted[95], shifted} + {{49{i_cfg.offset_value[47]}}, i_cfg.offset_value};

    // Output stage: clip to the signed 64-bit range
    assign fits    = (r5_sum[96:63] == '0) || (r5_sum[96:63] == '1);
    assign clipped = fits ? r5_sum[63:0]
                          : (r5_sum[96] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF);

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_tag  <= n1_tag;
            r1_xmag <= n_v[63] ? (64'd0 - n_v) : n_v;
            r1_smag <= i_cfg.scale_factor[31] ? (32'd0 - i_cfg.scale_factor)
                                              : i_cfg.scale_factor;
            r1_neg  <= n_v[63] ^ i_cfg.scale_factor[31];

            r2_tag  <= r1_tag;
            r2_neg  <= r1_neg;
            r2_p0   <= 64'(r1_xmag[31:0]) * 64'(r1_smag);
            r2_p1   <= 64'(r1_xmag[63:32]) * 64'(r1_smag);

            r3_tag  <= r2_tag;
            r3_neg  <= r2_neg;
            r3_prod <= {r2_p1, 32'b0} + {32'b0, r2_p0};

            r4_tag  <= r3_tag;
            r4_sp   <= r3_neg ? (96'd0 - r3_prod) : r3_prod;

            r5_tag  <= r4_tag;
            r5_sum  <= n_sum;

            r_out.int_value    <= r5_tag.v;
            r_out.scaled_value <= r5_tag.scl ? clipped : 64'd0;
            r_out.saturated    <= r5_tag.scl && !fits;
            r_out.status       <= r5_tag.status;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld      <= 1'b0;
            r2_vld      <= 1'b0;
            r3_vld      <= 1'b0;
            r4_vld      <= 1'b0;
            r5_vld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_vld      <= i_valid;
            r2_vld      <= r1_vld;
            r3_vld      <= r2_vld;
            r4_vld      <= r3_vld;
            r5_vld      <= r4_vld;
            r_out_valid <= r5_vld;
        end
    end

endmodule

// File: hw/rtl/modbus_register_value_decoder_core.sv
// A marked word's run passes the queue, pipe stages r1 to r5 and the output
// register to show as a result word. One register word per cycle while
// the queue has room; a new run enters the pipe each cycle unless stalled.
// Reset: synchronous, active low; clears the fold state, the queue, the pipe
// valid bits and restores the configuration registers to their reset values.
module modbus_register_value_decoder_core
    import mrvd_pkg::*;
#(
    parameter int MAX_WORDS = MAX_WORDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg r_cfg;
    logic push, full, q_valid, back_ready;
    t_job push_job, q_job;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.byte_order   <= 1'b0;
            r_cfg.signed_mode  <= 1'b0;
            r_cfg.value_format <= 1'b0;
            r_cfg.frac_bits    <= '0;
            r_cfg.scale_factor <= SCALE_RESET;
            r_cfg.offset_value <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BYTE_ORDER:   r_cfg.byte_order   <= i_cfg_wdata[0];
                CFG_SIGNED_MODE:  r_cfg.signed_mode  <= i_cfg_wdata[0];
                CFG_VALUE_FORMAT: r_cfg.value_format <= i_cfg_wdata[0];
                CFG_FRAC_BITS:    r_cfg.frac_bits    <= i_cfg_wdata[4:0];
                CFG_SCALE_FACTOR: r_cfg.scale_factor <= i_cfg_wdata[31:0];
                CFG_OFFSET_VALUE: r_cfg.offset_value <= i_cfg_wdata[47:0];
                default: begin
                end
            endcase
        end
    end

    mrvd_front #(
        .MAX_WORDS(MAX_WORDS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    mrvd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (back_ready),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    mrvd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .o_ready (back_ready),
        .i_job   (q_job),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

// File: hw/rtl/mrvd_checker.sv
module mrvd_checker
    import mrvd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_data
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    // Drop all values on an overlong run
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status |->
            o_out_data.int_value == '0 && o_out_data.scaled_value == '0 &&
            !o_out_data.saturated)
        else $error("overlong run carries a value");

    // Clip only to the range limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.saturated |->
            o_out_data.scaled_value == 64'h8000_0000_0000_0000 ||
            o_out_data.scaled_value == 64'h7FFF_FFFF_FFFF_FFFF)
        else $error("saturated result off the range limits");

    // Empty the pipe in reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid after reset");

    // Open the input side once reset has emptied the queue
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

endmodule

bind modbus_register_value_decoder_core mrvd_checker u_mrvd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: tb/modbus_register_value_decoder_core_test.sv
`timescale 1ns / 100ps

module modbus_register_value_decoder_core_test;
    import mrvd_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_WORDS = 1000;

    localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [47:0] OFS_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] OFS_MIN = 48'sh8000_0000_0000;

    // One directed stimulus row: optional reconfiguration, the word, an optional typed result
    typedef struct {
        bit        reconf;
        t_cfg      cfg;
        t_in_word  w;
        bit        typed;
        t_out_word r;
    } t_dir_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_data;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = CFG_BYTE_ORDER;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Sideband that travels with the input word: a typed result for directed rows
    logic      typed_flag = 1'b0;
    t_out_word typed_res  = '0;

    t_cfg      live_cfg;
    logic [63:0] fold_acc   = '0;
    int          fold_count = 0;
    bit          fold_long  = 1'b0;
    t_out_word   pending_values[$];
    int          mismatches  = 0;
    int          idle_cycles = 0;
    int          stall_left  = 0;
    bit          calm        = 1'b0;
    t_dir_row    directed[$];

    wire in_fire  = i_in_valid && o_in_ready;
    wire out_fire = o_out_valid && i_out_ready;

    modbus_register_value_decoder_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_cfg mk_cfg(bit bo, bit sm, bit vf, logic [4:0] frac,
                                    logic signed [31:0] scale, logic signed [47:0] ofs);
        t_cfg c;
        c.byte_order   = bo;
        c.signed_mode  = sm;
        c.value_format = vf;
        c.frac_bits    = frac;
        c.scale_factor = scale;
        c.offset_value = ofs;
        return c;
    endfunction

    // ((value * scale) >>> frac) + offset, exact in 128 bits, clipped to 64
    function automatic logic signed [63:0] scale_q48(logic signed [63:0] v, t_cfg c,
                                                     output logic sat);
        logic signed [127:0] prod;
        logic signed [127:0] sum;
        prod = v;
        prod = prod * $signed(c.scale_factor);
        prod = prod >>> c.frac_bits;
        sum  = prod + $signed(c.offset_value);
        sat  = !((&sum[127:63]) || !(|sum[127:63]));
        if (sat) begin
            return sum[127] ? Q_MIN : Q_MAX;
        end
        return sum[63:0];
    endfunction

    // Fold one word; return 1 with the decoded value when the word closes the run
    function automatic bit fold_register_word(t_in_word w, output t_out_word res);
        logic [63:0] v;
        logic        sat;
        res = '0;
        if (fold_count < MAX_WORDS_DEF) begin
            if (!live_cfg.value_format && live_cfg.byte_order) begin
                fold_acc = fold_acc | (64'({w.word[7:0], w.word[15:8]}) << (16 * fold_count));
            end else begin
                fold_acc = {fold_acc[47:0], w.word};
            end
            fold_count++;
        end else begin
            fold_long = 1'b1;
        end
        if (!w.last_word) begin
            return 1'b0;
        end
        if (fold_long) begin
            res.status = 1'b1;
        end else begin
            v = fold_acc;
            if (fold_count == 1) begin
                v = live_cfg.signed_mode ? {{48{v[15]}}, v[15:0]} : {48'b0, v[15:0]};
            end else if (fold_count == 2) begin
                v = live_cfg.signed_mode ? {{32{v[31]}}, v[31:0]} : {32'b0, v[31:0]};
            end
            res.int_value = v;
            if (live_cfg.value_format) begin
                res.scaled_value = scale_q48(v, live_cfg, sat);
                res.saturated    = sat;
            end
        end
        fold_acc   = '0;
        fold_count = 0;
        fold_long  = 1'b0;
        return 1'b1;
    endfunction

    function automatic int gap_len();
        int pick;
        if (calm) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return 0;
        end else if (pick < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.byte_order   = 1'($urandom_range(0, 1));
        c.signed_mode  = 1'($urandom_range(0, 1));
        c.value_format = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: c.frac_bits = 5'd0;
            1: c.frac_bits = 5'd31;
            2: c.frac_bits = 5'd16;
            default: c.frac_bits = 5'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0: c.scale_factor = 32'sh8000_0000;
            1: c.scale_factor = 32'sh7FFF_FFFF;
            2: c.scale_factor = SCALE_RESET;
            3: c.scale_factor = 32'sd0;
            default: c.scale_factor = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0: c.offset_value = OFS_MIN;
            1: c.offset_value = OFS_MAX;
            2: c.offset_value = '0;
            default: c.offset_value = {16'($urandom), 32'($urandom)};
        endcase
        return c;
    endfunction

    function automatic t_dir_row dr(bit reconf, t_cfg c, logic [15:0] w, bit last,
                                    bit typed, t_out_word r);
        t_dir_row row;
        row.reconf = reconf;
        row.cfg    = c;
        row.w      = {w, last};
        row.typed  = typed;
        row.r      = r;
        return row;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(t_dir_row row);
        directed.insert(directed.size(), row);
    endfunction

    // Present one word and hold it until accepted, then maybe pause
    task automatic send_word(t_in_word w, bit typed, t_out_word r);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        typed_flag <= typed;
        typed_res  <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every expected result is back and the pipe is empty
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_cfg(t_cfg c);
        drain();
        write_reg(CFG_BYTE_ORDER, 48'(c.byte_order));
        write_reg(CFG_SIGNED_MODE, 48'(c.signed_mode));
        write_reg(CFG_VALUE_FORMAT, 48'(c.value_format));
        write_reg(CFG_FRAC_BITS, 48'(c.frac_bits));
        write_reg(CFG_SCALE_FACTOR, {16'b0, c.scale_factor});
        write_reg(CFG_OFFSET_VALUE, c.offset_value);
        i_cfg_we <= 1'b0;
        live_cfg = c;
        @(posedge i_clk);
    endtask

    // Predict on every accepted input word
    always @(posedge i_clk) begin : predict
        t_out_word res;
        if (i_rst_n && in_fire) begin
            if (fold_register_word(i_in_data, res)) begin
                pending_values.insert(pending_values.size(), typed_flag ? typed_res : res);
            end
        end
    end

    // Compare every accepted result word with the oldest expectation
    always @(posedge i_clk) begin : check
        t_out_word exp_w;
        if (i_rst_n && out_fire) begin
            if (pending_values.size() == 0) begin
                $error("unexpected result word %h", o_out_data);
                mismatches++;
            end else begin
                exp_w = pending_values.pop_front();
                if (o_out_data.int_value !== exp_w.int_value) begin
                    $error("int_value: expected %h, got %h",
                           exp_w.int_value, o_out_data.int_value);
                    mismatches++;
                end
                if (o_out_data.scaled_value !== exp_w.scaled_value) begin
                    $error("scaled_value: expected %h, got %h",
                           exp_w.scaled_value, o_out_data.scaled_value);
                    mismatches++;
                end
                if (o_out_data.saturated !== exp_w.saturated) begin
                    $error("saturated: expected %b, got %b",
                           exp_w.saturated, o_out_data.saturated);
                    mismatches++;
                end
                if (o_out_data.status !== exp_w.status) begin
                    $error("status: expected %b, got %b", exp_w.status, o_out_data.status);
                    mismatches++;
                end
            end
        end
    end

    // Stall the result side: mostly short, a few long, none in calm phases
    always @(posedge i_clk) begin : ready_drive
        int pick;
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (calm) begin
            i_out_ready <= 1'b1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                i_out_ready <= 1'b1;
            end else if (pick < 93) begin
                i_out_ready <= 1'b0;
                stall_left  <= $urandom_range(0, 2);
            end else begin
                i_out_ready <= 1'b0;
                stall_left  <= $urandom_range(8, 30);
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || out_fire) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_cfg      cfg_plain;
        t_cfg      cfg_le_signed;
        t_cfg      cfg_scale_min;
        t_cfg      cfg_scale_sat;
        t_out_word none;
        int        sent;
        int        phase_words;
        int        phase_target;
        int        run_len;

        none          = '0;
        cfg_plain     = mk_cfg(0, 0, 0, 5'd0, SCALE_RESET, 48'sd0);
        cfg_le_signed = mk_cfg(1, 1, 0, 5'd0, SCALE_RESET, 48'sd0);
        cfg_scale_min = mk_cfg(0, 1, 1, 5'd31, 32'sh8000_0000, OFS_MAX);
        cfg_scale_sat = mk_cfg(0, 0, 1, 5'd0, 32'sh7FFF_FFFF, OFS_MAX);
        live_cfg      = cfg_plain;

        // Directed rows: unsigned one- and two-word, four-word, too long a run
        add_row(dr(1, cfg_plain, 16'hFFFF, 1, 1, {64'd65535, 64'd0, 1'b0, 1'b0}));
        add_row(dr(0, cfg_plain, 16'h0000, 1, 1, none));
        add_row(dr(0, cfg_plain, 16'h8000, 0, 0, none));
        add_row(dr(0, cfg_plain, 16'h0001, 1, 1,
                   {64'h0000_0000_8000_0001, 64'd0, 1'b0, 1'b0}));
        add_row(dr(0, cfg_plain, 16'h1234, 0, 0, none));
        add_row(dr(0, cfg_plain, 16'h5678, 0, 0, none));
        add_row(dr(0, cfg_plain, 16'h9ABC, 0, 0, none));
        add_row(dr(0, cfg_plain, 16'hDEF0, 1, 1,
                   {64'h1234_5678_9ABC_DEF0, 64'd0, 1'b0, 1'b0}));
        for (int k = 0; k < 4; k++) begin
            add_row(dr(0, cfg_plain, 16'hFFFF, 0, 0, none));
        end
        add_row(dr(0, cfg_plain, 16'h0001, 1, 1, {64'd0, 64'd0, 1'b0, 1'b1}));
        // Little-endian with byte swap, signed one-, two- and three-word
        add_row(dr(1, cfg_le_signed, 16'h0080, 1, 1,
                   {64'hFFFF_FFFF_FFFF_8000, 64'd0, 1'b0, 1'b0}));
        add_row(dr(0, cfg_le_signed, 16'h3412, 0, 0, none));
        add_row(dr(0, cfg_le_signed, 16'h0080, 1, 1,
                   {64'hFFFF_FFFF_8000_1234, 64'd0, 1'b0, 1'b0}));
        add_row(dr(0, cfg_le_signed, 16'hFFFF, 0, 0, none));
        add_row(dr(0, cfg_le_signed, 16'hFFFF, 0, 0, none));
        add_row(dr(0, cfg_le_signed, 16'hFFFF, 1, 1,
                   {64'h0000_FFFF_FFFF_FFFF, 64'd0, 1'b0, 1'b0}));
        // Scaled: most negative scale with the widest shift, then saturation high
        add_row(dr(1, cfg_scale_min, 16'h8000, 1, 0, none));
        for (int k = 0; k < 3; k++) begin
            add_row(dr(k == 0, cfg_scale_sat, k == 0 ? 16'h7FFF : 16'hFFFF, 0, 0, none));
        end
        add_row(dr(0, cfg_scale_sat, 16'hFFFF, 1, 1, {Q_MAX, Q_MAX, 1'b1, 1'b0}));
        add_row(dr(0, cfg_scale_sat, 16'h8000, 1, 0, none));

        // Hold reset, then release it
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (directed[k]) begin
            if (directed[k].reconf) begin
                apply_cfg(directed[k].cfg);
            end
            send_word(directed[k].w, directed[k].typed, directed[k].r);
        end

        // Random phases: new settings, then mostly well-formed runs
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            apply_cfg(random_cfg());
            calm         = ($urandom_range(0, 3) == 0);
            phase_words  = 0;
            phase_target = $urandom_range(40, 150);
            while (phase_words < phase_target) begin
                run_len = ($urandom_range(0, 99) < 88) ? $urandom_range(1, MAX_WORDS_DEF)
                                                       : $urandom_range(5, 7);
                for (int n = 0; n < run_len; n++) begin
                    send_word({pick_word(), n == run_len - 1}, 1'b0, none);
                end
                phase_words += run_len;
            end
            sent += phase_words;
        end

        drain();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/mrvd_pkg.sv
hw/rtl/mrvd_front.sv
hw/rtl/mrvd_queue.sv
hw/rtl/mrvd_back.sv
hw/rtl/modbus_register_value_decoder_core.sv
hw/rtl/mrvd_checker.sv
tb/modbus_register_value_decoder_core_test.sv
